// File: sv/msraf_pkg.sv
// Shared types, codes and constants of the register access filter.
`timescale 1ns / 1ps

package msraf_pkg;

    localparam int RANGE_ENTRIES = 8192;
    localparam int RANGE_BITS    = $clog2(RANGE_ENTRIES);
    localparam int MAP_BITS      = 2 * RANGE_ENTRIES;
    localparam int SLOT_W        = $clog2(MAP_BITS);
    localparam int WORD_W        = 64;
    localparam int BIT_W         = $clog2(WORD_W);
    localparam int MAP_ROWS      = MAP_BITS / WORD_W;
    localparam int ROW_W         = $clog2(MAP_ROWS);

    localparam logic [31:0] HIGH_BASE     = 32'hC000_0000;
    localparam logic [31:0] CAP_FIRST     = 32'h0000_0480;
    localparam logic [31:0] CAP_LAST      = 32'h0000_0491;
    localparam logic [31:0] FEATURE_CTL   = 32'h0000_003A;
    localparam logic [31:0] VM_CR         = 32'hC001_0114;
    localparam logic [31:0] VM_HSAVE_KEY  = 32'hC001_0117;
    localparam logic [31:0] SYNTH_FIRST   = 32'h4000_0000;
    localparam logic [31:0] SYNTH_LAST    = 32'h4000_00FF;
    localparam logic [31:0] DEBUGCTL      = 32'h0000_01D9;

    localparam logic [WORD_W-1:0] VM_CR_SET_BITS  = 64'h0000_0000_0000_0018;
    localparam logic [WORD_W-1:0] DEBUGCTL_HIDE   = 64'h0000_0000_0000_0043;
    localparam logic [WORD_W-1:0] FEATURE_CTL_VAL = 64'h0000_0000_0000_0001;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_PROBE = 2'd2,
        CMD_RSVD  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_VALUE = 2'd0,
        ACT_PASS  = 2'd1,
        ACT_FAULT = 2'd2,
        ACT_PROBE = 2'd3
    } t_action;

    typedef struct packed {
        logic              cap;
        logic              feature_ctl;
        logic              vm_cr;
        logic              hsave_key;
        logic              synthetic;
        logic              debugctl;
        logic              covered;
        logic [SLOT_W-1:0] slot;
    } t_msr_class;

endpackage

// File: sv/msraf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module msraf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/msraf_decode.sv
// Register number decoder: special registers, ranges and map slot.
`timescale 1ns / 1ps

module msraf_decode
    import msraf_pkg::*;
(
    input  logic [31:0] i_msr_index,
    output t_msr_class  o_class
);

    logic is_low;
    logic is_high;

    assign is_low  = (i_msr_index[31:RANGE_BITS] == '0);
    assign is_high = (i_msr_index[31:RANGE_BITS] == HIGH_BASE[31:RANGE_BITS]);

    always_comb begin
        o_class.cap         = (i_msr_index >= CAP_FIRST) && (i_msr_index <= CAP_LAST);
        o_class.feature_ctl = (i_msr_index == FEATURE_CTL);
        o_class.vm_cr       = (i_msr_index == VM_CR);
        o_class.hsave_key   = (i_msr_index == VM_HSAVE_KEY);
        o_class.synthetic   = (i_msr_index >= SYNTH_FIRST) && (i_msr_index <= SYNTH_LAST);
        o_class.debugctl    = (i_msr_index == DEBUGCTL);
        o_class.covered     = is_low || is_high;
        o_class.slot        = {is_high, i_msr_index[RANGE_BITS-1:0]};
    end

endmodule

// File: sv/msr_access_filter.sv
// Top level of the register access filter with its invalid-register map.
`timescale 1ns / 1ps
// Path: an access transferred in is held in the stage-one register, and its result in the
// output register. Throughput: one access per cycle while the output is not stalled; the map
// row is read at transfer, and a probe of a covered register writes it back as it leaves
// stage one, with forwarding when the next access hits that row. Reset: after reset the map
// is cleared one 64-bit row per cycle, all 256 rows; no access is taken during that pass.

module msr_access_filter
    import msraf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_msr_index,
    input  logic [63:0] i_current_value,
    input  logic [63:0] i_write_value,
    input  logic        i_spoof_debug,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_action,
    output logic [63:0] o_result_value,
    output logic [31:0] o_target_index
);

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    t_state              r_state;
    logic [ROW_W-1:0]    r_clr_row;

    logic                r_s1_valid;
    t_cmd                r_s1_cmd;
    t_msr_class          r_s1_cls;
    logic [31:0]         r_s1_num;
    logic [WORD_W-1:0]   r_s1_cur;
    logic [WORD_W-1:0]   r_s1_wv;
    logic                r_s1_spoof;
    logic                r_s1_hit;
    logic [WORD_W-1:0]   r_s1_hit_data;

    logic                r_out_valid;
    t_action             r_action;
    logic [WORD_W-1:0]   r_value;
    logic [31:0]         r_target;

    t_msr_class          in_cls;
    logic                in_acc;
    logic                s1_adv;
    logic                s1_write;
    logic [ROW_W-1:0]    s1_row;
    logic [BIT_W-1:0]    s1_bit;
    logic [WORD_W-1:0]   ram_rdata;
    logic [WORD_W-1:0]   row_data;
    logic [WORD_W-1:0]   row_marked;
    logic                marked;

    logic                ram_we;
    logic [ROW_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;

    t_action             n_action;
    logic [WORD_W-1:0]   n_value;
    logic [31:0]         n_target;

    msraf_decode u_decode (
        .i_msr_index (i_msr_index),
        .o_class     (in_cls)
    );

    msraf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (in_cls.slot[SLOT_W-1:BIT_W]),
        .o_rdata (ram_rdata)
    );

    assign s1_row     = r_s1_cls.slot[SLOT_W-1:BIT_W];
    assign s1_bit     = r_s1_cls.slot[BIT_W-1:0];
    assign row_data   = r_s1_hit ? r_s1_hit_data : ram_rdata;
    assign marked     = row_data[s1_bit];
    assign row_marked = row_data | (WORD_W'(1) << s1_bit);

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign s1_write   = s1_adv && (r_s1_cmd == CMD_PROBE) && r_s1_cls.covered;
    assign o_in_stall = (r_state == ST_CLEAR) || (r_s1_valid && !s1_adv);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_row;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_write;
            ram_waddr = s1_row;
            ram_wdata = row_marked;
        end
    end

    always_comb begin
        n_action = ACT_FAULT;
        n_value  = '0;
        n_target = '0;
        unique case (r_s1_cmd)
            CMD_READ: begin
                priority if (r_s1_cls.cap || r_s1_cls.hsave_key) begin
                    n_action = ACT_VALUE;
                end else if (r_s1_cls.feature_ctl) begin
                    n_action = ACT_VALUE;
                    n_value  = FEATURE_CTL_VAL;
                end else if (r_s1_cls.vm_cr) begin
                    n_action = ACT_VALUE;
                    n_value  = r_s1_cur | VM_CR_SET_BITS;
                end else if (r_s1_cls.synthetic || !r_s1_cls.covered || marked) begin
                    n_action = ACT_FAULT;
                end else begin
                    n_action = ACT_VALUE;
                    n_value  = (r_s1_spoof && r_s1_cls.debugctl)
                             ? (r_s1_cur & ~DEBUGCTL_HIDE) : r_s1_cur;
                end
            end
            CMD_WRITE: begin
                if (r_s1_cls.cap || r_s1_cls.feature_ctl || r_s1_cls.vm_cr
                        || r_s1_cls.hsave_key || r_s1_cls.synthetic
                        || !r_s1_cls.covered || marked) begin
                    n_action = ACT_FAULT;
                end else begin
                    n_action = ACT_PASS;
                    n_value  = r_s1_wv;
                    n_target = r_s1_num;
                end
            end
            CMD_PROBE: begin
                n_action = ACT_PROBE;
            end
            CMD_RSVD: begin
                n_action = ACT_FAULT;
            end
            default: begin
                n_action = ACT_FAULT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_row   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_row <= r_clr_row + ROW_W'(1);
                    if (r_clr_row == {ROW_W{1'b1}}) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_clr_row <= r_clr_row;
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase

            if (in_acc) begin
                r_s1_valid    <= 1'b1;
                r_s1_cmd      <= t_cmd'(i_command);
                r_s1_cls      <= in_cls;
                r_s1_num      <= i_msr_index;
                r_s1_cur      <= i_current_value;
                r_s1_wv       <= i_write_value;
                r_s1_spoof    <= i_spoof_debug;
                r_s1_hit      <= s1_write && (s1_row == in_cls.slot[SLOT_W-1:BIT_W]);
                r_s1_hit_data <= row_marked;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_action    <= n_action;
                r_value     <= n_value;
                r_target    <= n_target;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_action       = r_action;
    assign o_result_value = r_value;
    assign o_target_index = r_target;

endmodule

// File: sv/msraf_checker.sv
// Port-level checker of the register access filter and its bind to the top level.
`timescale 1ns / 1ps

module msraf_checker
    import msraf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_action,
    input logic [63:0] o_result_value,
    input logic [31:0] o_target_index
);

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("Access taken before the map clear pass.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_action)
            && $stable(o_result_value) && $stable(o_target_index))
        else $error("Stalled result transfer changed.");

    a_target_only_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_action != ACT_PASS) |-> (o_target_index == '0))
        else $error("Register number shown on a result that is not a pass-through.");

    a_no_value_fault_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_action == ACT_FAULT) || (o_action == ACT_PROBE))
            |-> (o_result_value == '0))
        else $error("Fault or probe result carries a value.");

endmodule

bind msr_access_filter msraf_checker u_msraf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_action       (o_action),
    .o_result_value (o_result_value),
    .o_target_index (o_target_index)
);
